/* rtl/tccw_pkg.sv */
// Shared constants, types and helper functions of the text console cell writer.
// No dependencies; the top, the engine and the testbench import this package.
package tccw_pkg;

    localparam int SCROLLBACK_LINES = 1024;
    localparam int MAX_COLS = 128;
    localparam int MAX_ROWS = 64;
    localparam int ROWS_LIMIT = (MAX_ROWS < SCROLLBACK_LINES - 1) ? MAX_ROWS
                                                                  : SCROLLBACK_LINES - 1;

    localparam int LINE_W = $clog2(SCROLLBACK_LINES);
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ADDR_W = LINE_W + COL_W;
    localparam int MEM_DEPTH = SCROLLBACK_LINES * MAX_COLS;

    localparam int CHAR_W = 8;
    localparam int MODE_W = 2;
    localparam int ROW_W = 6;
    localparam int OUT_COL_W = 7;
    localparam int HIST_W = 10;
    localparam int COLS_REG_W = 8;
    localparam int ROWS_REG_W = 7;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [MODE_W-1:0] MODE_PUT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BLINK = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b1;

    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_RETURN = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

    localparam logic [COLS_REG_W-1:0] COLS_RESET = 8'd80;
    localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 7'd24;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [CHAR_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic                 valid;
        logic [OUT_COL_W-1:0] cursor_column;
        logic [ROW_W-1:0]     cursor_row;
        logic [HIST_W-1:0]    history_count;
        logic [CHAR_W-1:0]    cell_char;
        logic                 cell_cursor;
    } result_t;

    function automatic logic [COLS_REG_W-1:0] eff_cols_f(input logic [COLS_REG_W-1:0] v);
        logic [COLS_REG_W-1:0] c;
        c = v;
        if (c == '0)
        begin
            c = COLS_REG_W'(1);
        end
        if (c > COLS_REG_W'(MAX_COLS))
        begin
            c = COLS_REG_W'(MAX_COLS);
        end
        return c;
    endfunction

    function automatic logic [ROWS_REG_W-1:0] eff_rows_f(input logic [ROWS_REG_W-1:0] v);
        logic [ROWS_REG_W-1:0] r;
        r = v;
        if (r == '0)
        begin
            r = ROWS_REG_W'(1);
        end
        if (r > ROWS_REG_W'(ROWS_LIMIT))
        begin
            r = ROWS_REG_W'(ROWS_LIMIT);
        end
        return r;
    endfunction

endpackage

/* rtl/text_console_cell_writer_top.sv */
// Text console cell writer: an accepted word goes through the engine's execute state to
// the result register; an item that scrolls first clears one new line, a cell per cycle.
// A new item is taken only after the last one has gone to the result register.
// After reset a clearing pass fills the store with spaces; items
// stall during it, config words are taken. Holds the result register; depends on
// tccw_pkg, tccw_ram and tccw_engine.
module text_console_cell_writer_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [tccw_pkg::MODE_W-1:0]         mode,
    input  logic [tccw_pkg::CHAR_W-1:0]         char_code,
    input  logic [tccw_pkg::ROW_W-1:0]          read_row,
    input  logic [tccw_pkg::OUT_COL_W-1:0]      read_col,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic [tccw_pkg::OUT_COL_W-1:0]      cursor_column,
    output logic [tccw_pkg::ROW_W-1:0]          cursor_row,
    output logic [tccw_pkg::HIST_W-1:0]         history_count,
    output logic [tccw_pkg::CHAR_W-1:0]         cell_char,
    output logic                                cell_cursor,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tccw_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import tccw_pkg::*;

    mem_req_t mem_req;
    result_t res;
    logic [CHAR_W-1:0] mem_rdata;
    logic out_free;

    logic result_valid_reg, result_valid_next;
    logic [OUT_COL_W-1:0] cursor_column_reg;
    logic [ROW_W-1:0] cursor_row_reg;
    logic [HIST_W-1:0] history_count_reg;
    logic [CHAR_W-1:0] cell_char_reg;
    logic cell_cursor_reg;

    tccw_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(MEM_DEPTH)
    ) u_store (
        .clk(clk),
        .we(mem_req.we),
        .waddr(mem_req.waddr),
        .wdata(mem_req.wdata),
        .re(mem_req.re),
        .raddr(mem_req.raddr),
        .rdata(mem_rdata)
    );

    tccw_engine u_engine (
        .clk(clk),
        .rst_n(rst_n),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .mode(mode),
        .char_code(char_code),
        .read_row(read_row),
        .read_col(read_col),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .out_free(out_free),
        .res(res),
        .mem_req(mem_req),
        .mem_rdata(mem_rdata)
    );

    assign out_free = !result_valid_reg || !result_stall;

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (res.valid)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    // load a new word only when the slot is free
    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            cursor_column_reg <= res.cursor_column;
            cursor_row_reg <= res.cursor_row;
            history_count_reg <= res.history_count;
            cell_char_reg <= res.cell_char;
            cell_cursor_reg <= res.cell_cursor;
        end
    end

    assign result_valid = result_valid_reg;
    assign cursor_column = cursor_column_reg;
    assign cursor_row = cursor_row_reg;
    assign history_count = history_count_reg;
    assign cell_char = cell_char_reg;
    assign cell_cursor = cell_cursor_reg;

endmodule

/* rtl/tccw_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module tccw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/tccw_engine.sv */
// Terminal engine: cursor, scroll ring, blink and config state, sequencer driving
// the character store. Depends on tccw_pkg.
module tccw_engine (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic [tccw_pkg::MODE_W-1:0]         mode,
    input  logic [tccw_pkg::CHAR_W-1:0]         char_code,
    input  logic [tccw_pkg::ROW_W-1:0]          read_row,
    input  logic [tccw_pkg::OUT_COL_W-1:0]      read_col,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tccw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tccw_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                out_free,
    output tccw_pkg::result_t                   res,
    output tccw_pkg::mem_req_t                  mem_req,
    input  logic [tccw_pkg::CHAR_W-1:0]         mem_rdata
);

    import tccw_pkg::*;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] init_addr_reg, init_addr_next;
    logic [COL_W-1:0] clr_col_reg, clr_col_next;
    logic [LINE_W-1:0] clr_line_reg, clr_line_next;
    logic [LINE_W-1:0] base_reg, base_next;
    logic [OUT_COL_W-1:0] cur_col_reg, cur_col_next;
    logic [ROW_W-1:0] cur_row_reg, cur_row_next;
    logic [HIST_W-1:0] hist_reg, hist_next;
    logic skip_reg, skip_next;
    logic mark_reg, mark_next;
    logic [COLS_REG_W-1:0] eff_cols_reg, eff_cols_next;
    logic [ROWS_REG_W-1:0] eff_rows_reg, eff_rows_next;
    logic [CHAR_W-1:0] rd_char_reg, rd_char_next;
    logic rd_mark_reg, rd_mark_next;

    logic [MODE_W-1:0] mode_q_reg;
    logic [CHAR_W-1:0] char_q_reg;
    logic [ROW_W-1:0] rrow_q_reg;
    logic [OUT_COL_W-1:0] rcol_q_reg;
    logic rd_ok_q_reg;

    logic item_accept;
    logic cfg_accept;
    logic rd_in_range;

    assign cfg_ready = (state_reg == ST_IDLE) || (state_reg == ST_INIT);
    assign item_stall = (state_reg != ST_IDLE) || cfg_valid;
    assign item_accept = item_valid && !item_stall;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign rd_in_range = ({1'b0, read_row} < eff_rows_reg)
                      && ({1'b0, read_col} < eff_cols_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            init_addr_reg <= '0;
            clr_col_reg <= '0;
            clr_line_reg <= '0;
            base_reg <= '0;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            hist_reg <= '0;
            skip_reg <= 1'b1;
            mark_reg <= 1'b1;
            eff_cols_reg <= COLS_RESET;
            eff_rows_reg <= ROWS_RESET;
        end
        else
        begin
            state_reg <= state_next;
            init_addr_reg <= init_addr_next;
            clr_col_reg <= clr_col_next;
            clr_line_reg <= clr_line_next;
            base_reg <= base_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
            hist_reg <= hist_next;
            skip_reg <= skip_next;
            mark_reg <= mark_next;
            eff_cols_reg <= eff_cols_next;
            eff_rows_reg <= eff_rows_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_char_reg <= rd_char_next;
        rd_mark_reg <= rd_mark_next;
        if (item_accept)
        begin
            mode_q_reg <= mode;
            char_q_reg <= char_code;
            rrow_q_reg <= read_row;
            rcol_q_reg <= read_col;
            rd_ok_q_reg <= rd_in_range;
        end
    end

    always_comb
    begin
        logic [OUT_COL_W:0] col_w;
        logic [ROW_W:0] row_w;
        logic [LINE_W:0] hist_inc;
        logic [LINE_W:0] hist_cap;
        logic [COLS_REG_W-1:0] cfg_cols;
        logic [ROWS_REG_W-1:0] cfg_rows;
        logic scroll;

        state_next = state_reg;
        init_addr_next = init_addr_reg;
        clr_col_next = clr_col_reg;
        clr_line_next = clr_line_reg;
        base_next = base_reg;
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        hist_next = hist_reg;
        skip_next = skip_reg;
        mark_next = mark_reg;
        eff_cols_next = eff_cols_reg;
        eff_rows_next = eff_rows_reg;
        rd_char_next = rd_char_reg;
        rd_mark_next = rd_mark_reg;
        mem_req = '0;
        res = '0;
        col_w = '0;
        row_w = '0;
        hist_inc = '0;
        hist_cap = '0;
        scroll = 1'b0;
        cfg_cols = eff_cols_reg;
        cfg_rows = eff_rows_reg;

        // clamp cursor and history into the new limits
        if (cfg_accept)
        begin
            if (cfg_index == CFG_COLS)
            begin
                cfg_cols = eff_cols_f(cfg_data);
            end
            if (cfg_index == CFG_ROWS)
            begin
                cfg_rows = eff_rows_f(cfg_data[ROWS_REG_W-1:0]);
            end
            eff_cols_next = cfg_cols;
            eff_rows_next = cfg_rows;
            if ({1'b0, cur_col_reg} >= cfg_cols)
            begin
                cur_col_next = OUT_COL_W'(cfg_cols - COLS_REG_W'(1));
            end
            if ({1'b0, cur_row_reg} >= cfg_rows)
            begin
                cur_row_next = ROW_W'(cfg_rows - ROWS_REG_W'(1));
            end
            hist_cap = (LINE_W + 1)'(SCROLLBACK_LINES) - (LINE_W + 1)'(cfg_rows);
            if ({1'b0, hist_reg} > hist_cap)
            begin
                hist_next = hist_cap[HIST_W-1:0];
            end
            skip_next = 1'b1;
            mark_next = 1'b1;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                mem_req.we = 1'b1;
                mem_req.waddr = init_addr_reg;
                mem_req.wdata = CH_SPACE;
                init_addr_next = init_addr_reg + ADDR_W'(1);
                if (init_addr_reg == ADDR_W'(MEM_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    mem_req.re = (mode == MODE_READ);
                    mem_req.raddr = {LINE_W'(base_reg + LINE_W'(read_row)), read_col};
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                rd_char_next = '0;
                rd_mark_next = 1'b0;
                case (mode_q_reg)
                    MODE_PUT:
                    begin
                        if (char_q_reg == CH_NEWLINE)
                        begin
                            col_w = {1'b0, cur_col_reg};
                            row_w = {1'b0, cur_row_reg} + (ROW_W + 1)'(1);
                        end
                        else if (char_q_reg == CH_RETURN)
                        begin
                            col_w = '0;
                            row_w = {1'b0, cur_row_reg};
                        end
                        else
                        begin
                            mem_req.we = 1'b1;
                            mem_req.waddr = {LINE_W'(base_reg + LINE_W'(cur_row_reg)),
                                             cur_col_reg};
                            mem_req.wdata = char_q_reg;
                            col_w = {1'b0, cur_col_reg} + (OUT_COL_W + 1)'(1);
                            row_w = {1'b0, cur_row_reg};
                        end
                        if (col_w >= eff_cols_reg)
                        begin
                            col_w = '0;
                            row_w = row_w + (ROW_W + 1)'(1);
                        end
                        if (row_w >= eff_rows_reg)
                        begin
                            scroll = 1'b1;
                            base_next = base_reg + LINE_W'(1);
                            row_w = eff_rows_reg - ROWS_REG_W'(1);
                            hist_inc = {1'b0, hist_reg} + (LINE_W + 1)'(1);
                            hist_cap = (LINE_W + 1)'(SCROLLBACK_LINES)
                                     - (LINE_W + 1)'(eff_rows_reg);
                            hist_next = (hist_inc > hist_cap) ? hist_cap[HIST_W-1:0]
                                                              : hist_inc[HIST_W-1:0];
                            clr_line_next = LINE_W'(base_reg + LINE_W'(eff_rows_reg));
                            clr_col_next = '0;
                        end
                        cur_col_next = col_w[OUT_COL_W-1:0];
                        cur_row_next = row_w[ROW_W-1:0];
                        skip_next = 1'b1;
                        mark_next = 1'b1;
                    end
                    MODE_BLINK:
                    begin
                        if (skip_reg)
                        begin
                            skip_next = 1'b0;
                        end
                        else
                        begin
                            mark_next = !mark_reg;
                        end
                    end
                    MODE_READ:
                    begin
                        if (rd_ok_q_reg)
                        begin
                            rd_char_next = mem_rdata;
                            rd_mark_next = mark_reg && (rrow_q_reg == cur_row_reg)
                                        && (rcol_q_reg == cur_col_reg);
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (scroll)
                begin
                    state_next = ST_SCROLL;
                end
                else if (out_free)
                begin
                    res.valid = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_SCROLL:
            begin
                mem_req.we = 1'b1;
                mem_req.waddr = {clr_line_reg, clr_col_reg};
                mem_req.wdata = CH_SPACE;
                clr_col_next = clr_col_reg + COL_W'(1);
                if (clr_col_reg == COL_W'(MAX_COLS - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    res.valid = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        res.cursor_column = cur_col_next;
        res.cursor_row = cur_row_next;
        res.history_count = hist_next;
        res.cell_char = rd_char_next;
        res.cell_cursor = rd_mark_next;
    end

endmodule

/* dv/text_console_cell_writer_top_test.sv */
// Self-checking testbench for text_console_cell_writer_top: directed and random
// character, blink and read words, checked against a cell-level mirror of the console.
// Depends on tccw_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module text_console_cell_writer_top_test;
    import tccw_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 160;

    typedef struct packed {
        logic [OUT_COL_W-1:0] cursor_column;
        logic [ROW_W-1:0]     cursor_row;
        logic [HIST_W-1:0]    history_count;
        logic [CHAR_W-1:0]    cell_char;
        logic                 cell_cursor;
    } console_status_t;

    class console_mirror;
        logic [8:0] cells [SCROLLBACK_LINES * MAX_COLS];
        int base_line;
        int cur_col;
        int cur_row;
        int hist;
        bit blink_skip;
        int cols_reg;
        int rows_reg;
        int errors;
        console_status_t expected_status[$];

        function new();
            foreach (cells[i])
            begin
                cells[i] = {1'b0, CH_SPACE};
            end
            base_line = 0;
            cur_col = 0;
            cur_row = 0;
            hist = 0;
            blink_skip = 1'b1;
            cols_reg = int'(COLS_RESET);
            rows_reg = int'(ROWS_RESET);
            errors = 0;
            cells[slot(0, 0)][8] = 1'b1;
        endfunction

        function int width();
            int c;
            c = cols_reg;
            if (c < 1)
            begin
                c = 1;
            end
            if (c > MAX_COLS)
            begin
                c = MAX_COLS;
            end
            return c;
        endfunction

        function int height();
            int r;
            int top;
            r = rows_reg;
            top = (MAX_ROWS < SCROLLBACK_LINES - 1) ? MAX_ROWS : SCROLLBACK_LINES - 1;
            if (r < 1)
            begin
                r = 1;
            end
            if (r > top)
            begin
                r = top;
            end
            return r;
        endfunction

        function int slot(int row, int col);
            return ((base_line + row) % SCROLLBACK_LINES) * MAX_COLS + (col % MAX_COLS);
        endfunction

        function void trim_history();
            if (hist > SCROLLBACK_LINES - height())
            begin
                hist = SCROLLBACK_LINES - height();
            end
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void move_to(int col, int row);
            int w;
            int h;
            int i;
            w = width();
            h = height();
            cells[slot(cur_row, cur_col)][8] = 1'b0;
            if (col >= w)
            begin
                col = 0;
                row = row + 1;
            end
            if (row >= h)
            begin
                base_line = (base_line + 1) % SCROLLBACK_LINES;
                row = h - 1;
                for (i = 0; i < MAX_COLS; i++)
                begin
                    cells[slot(row, i)] = {1'b0, CH_SPACE};
                end
                hist = hist + 1;
                trim_history();
            end
            cur_col = col;
            cur_row = row;
            cells[slot(cur_row, cur_col)][8] = 1'b1;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            cells[slot(cur_row, cur_col)][8] = 1'b0;
            if (idx == CFG_COLS)
            begin
                cols_reg = int'(val);
            end
            else
            begin
                rows_reg = int'(val[ROWS_REG_W-1:0]);
            end
            if (cur_col >= width())
            begin
                cur_col = width() - 1;
            end
            if (cur_row >= height())
            begin
                cur_row = height() - 1;
            end
            trim_history();
            cells[slot(cur_row, cur_col)][8] = 1'b1;
            blink_skip = 1'b1;
        endfunction

        function void note_item(logic [MODE_W-1:0] m, logic [CHAR_W-1:0] ch,
                                logic [ROW_W-1:0] rr, logic [OUT_COL_W-1:0] rc);
            console_status_t s;
            int a;
            s = '0;
            case (m)
                MODE_PUT:
                begin
                    if (ch == CH_NEWLINE)
                    begin
                        move_to(cur_col, cur_row + 1);
                    end
                    else if (ch == CH_RETURN)
                    begin
                        move_to(0, cur_row);
                    end
                    else
                    begin
                        cells[slot(cur_row, cur_col)] = {1'b0, ch};
                        move_to(cur_col + 1, cur_row);
                    end
                    blink_skip = 1'b1;
                end
                MODE_BLINK:
                begin
                    if (blink_skip)
                    begin
                        blink_skip = 1'b0;
                    end
                    else
                    begin
                        a = slot(cur_row, cur_col);
                        cells[a][8] = ~cells[a][8];
                    end
                end
                MODE_READ:
                begin
                    if (int'(rr) < height() && int'(rc) < width())
                    begin
                        a = slot(int'(rr), int'(rc));
                        s.cell_char = cells[a][7:0];
                        s.cell_cursor = cells[a][8];
                    end
                end
                default:
                begin
                end
            endcase
            s.cursor_column = OUT_COL_W'(cur_col);
            s.cursor_row = ROW_W'(cur_row);
            s.history_count = HIST_W'(hist);
            expected_status.push_back(s);
        endfunction

        function void compare_field(string field, int want, int got);
            if (want != got)
            begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(console_status_t got);
            console_status_t want;
            if (expected_status.size() == 0)
            begin
                $error("result word with no item pending");
                errors++;
                return;
            end
            want = expected_status.pop_front();
            compare_field("cursor_column", int'(want.cursor_column), int'(got.cursor_column));
            compare_field("cursor_row", int'(want.cursor_row), int'(got.cursor_row));
            compare_field("history_count", int'(want.history_count), int'(got.history_count));
            compare_field("cell_char", int'(want.cell_char), int'(got.cell_char));
            compare_field("cell_cursor", int'(want.cell_cursor), int'(got.cell_cursor));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic item_valid;
    logic item_stall;
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0] read_row;
    logic [OUT_COL_W-1:0] read_col;
    logic result_valid;
    logic result_stall = 1'b0;
    logic [OUT_COL_W-1:0] cursor_column;
    logic [ROW_W-1:0] cursor_row;
    logic [HIST_W-1:0] history_count;
    logic [CHAR_W-1:0] cell_char;
    logic cell_cursor;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    console_mirror mirror;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit long_hold_req = 1'b0;
    logic long_hold = 1'b0;
    int unsigned cycle_count = 0;

    text_console_cell_writer_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .mode          (mode),
        .char_code     (char_code),
        .read_row      (read_row),
        .read_col      (read_col),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row),
        .history_count (history_count),
        .cell_char     (cell_char),
        .cell_cursor   (cell_cursor),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        result_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
    end

    // hold off the result side long enough for the block to back up
    initial
    begin
        wait (long_hold_req);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            mirror.check_result({cursor_column, cursor_row, history_count, cell_char,
                                 cell_cursor});
        end
    end

    task automatic send_item(input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] ch,
                             input logic [ROW_W-1:0] rr, input logic [OUT_COL_W-1:0] rc);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        mode <= m;
        char_code <= ch;
        read_row <= rr;
        read_col <= rc;
        do
            @(posedge clk);
        while (item_stall);
        mirror.note_item(m, ch, rr, rc);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        mirror.apply_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        while (mirror.pending() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic run_phase(input logic [CFG_DATA_W-1:0] cols_val,
                             input logic [CFG_DATA_W-1:0] rows_val, input int count,
                             input int idle_pct, input int stall_pct, input bit hold,
                             input int put_pct, input int newline_pct);
        logic [MODE_W-1:0] m;
        logic [CHAR_W-1:0] ch;
        logic [ROW_W-1:0] rr;
        logic [OUT_COL_W-1:0] rc;
        int pick;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        write_reg(CFG_COLS, cols_val);
        write_reg(CFG_ROWS, rows_val);
        if (hold)
        begin
            long_hold_req = 1'b1;
        end
        repeat (count)
        begin
            ch = CHAR_W'($urandom);
            rr = ROW_W'($urandom);
            rc = OUT_COL_W'($urandom);
            if ($urandom_range(99) < put_pct)
            begin
                m = MODE_PUT;
                if ($urandom_range(99) < newline_pct)
                begin
                    ch = CH_NEWLINE;
                end
                else if ($urandom_range(99) < 3)
                begin
                    ch = CH_RETURN;
                end
            end
            else
            begin
                pick = $urandom_range(9);
                if (pick < 4)
                begin
                    m = MODE_BLINK;
                end
                else if (pick < 9)
                begin
                    m = MODE_READ;
                    if ($urandom_range(99) < 70)
                    begin
                        rr = ROW_W'($urandom_range(mirror.height() - 1));
                        rc = OUT_COL_W'($urandom_range(mirror.width() - 1));
                    end
                end
                else
                begin
                    m = MODE_SPARE;
                end
            end
            send_item(m, ch, rr, rc);
        end
        wait_drained();
    endtask

    initial
    begin
        mirror = new();
        rst_n = 1'b0;
        item_valid = 1'b0;
        mode = MODE_PUT;
        char_code = '0;
        read_row = '0;
        read_col = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_COLS;
        cfg_data = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_item(MODE_READ, 8'h00, 6'd0, 7'd0);
        send_item(MODE_BLINK, 8'h00, 6'd0, 7'd0);
        send_item(MODE_BLINK, 8'h00, 6'd0, 7'd0);
        send_item(MODE_READ, 8'h00, 6'd0, 7'd0);
        send_item(MODE_BLINK, 8'h00, 6'd0, 7'd0);
        send_item(MODE_PUT, 8'h00, 6'd0, 7'd0);
        send_item(MODE_PUT, 8'hFF, 6'd0, 7'd0);
        send_item(MODE_PUT, CH_RETURN, 6'd0, 7'd0);
        send_item(MODE_PUT, CH_NEWLINE, 6'd0, 7'd0);
        send_item(MODE_PUT, 8'h41, 6'd0, 7'd0);
        send_item(MODE_BLINK, 8'h00, 6'd0, 7'd0);
        send_item(MODE_BLINK, 8'h00, 6'd0, 7'd0);
        send_item(MODE_READ, 8'h00, 6'd0, 7'd0);
        send_item(MODE_READ, 8'h00, 6'd0, 7'd1);
        send_item(MODE_READ, 8'h00, 6'd1, 7'd0);
        send_item(MODE_READ, 8'h00, 6'd1, 7'd1);
        send_item(MODE_READ, 8'h00, 6'd23, 7'd79);
        send_item(MODE_READ, 8'h00, 6'd24, 7'd0);
        send_item(MODE_READ, 8'h00, 6'd0, 7'd80);
        send_item(MODE_READ, 8'hFF, 6'd63, 7'd127);
        send_item(MODE_SPARE, 8'hFF, 6'd63, 7'd127);
        wait_drained();

        run_phase(8'd128, 8'd64, 60, 0, 0, 1'b0, 70, 10);
        run_phase(8'd0, 8'd0, 540, 57, 0, 1'b0, 95, 30);
        run_phase(8'd3, 8'd2, 100, 0, 57, 1'b1, 80, 20);
        run_phase(8'd1, 8'd1, 520, 38, 38, 1'b0, 95, 30);
        run_phase(8'd255, 8'hFF, 110, 0, 0, 1'b0, 85, 60);
        run_phase(8'd40, 8'd10, 40, 38, 38, 1'b0, 70, 15);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mirror.pending() != 0)
        begin
            $error("%0d results never arrived", mirror.pending());
        end
        if (mirror.errors == 0 && mirror.pending() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
